/* src/eds_pkg.sv */
// Shared widths, types and constant divider factors for the echo distance smoother.
package eds_pkg;

  localparam int SENSOR_COUNT  = 3;
  localparam int WINDOW_LENGTH = 6;

  localparam int SENSOR_W = 2;
  localparam int TIME_W   = 32;
  localparam int CM_W     = 10;
  localparam int DIST_W   = 14;
  localparam int FRAC_W   = 4;
  localparam int POS_W    = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;

  localparam logic [CM_W-1:0] MAX_CM_RESET = CM_W'(400);

  // Distance in 1/16 cm is width*16/58. Any pulse of 2**16 us or more is already past
  // the largest possible limit, so only the low bits of the width go through the divider.
  localparam int WIDTH_KEEP_W = 16;
  localparam int DIST_NUM     = 16;
  localparam int DIST_DEN     = 58;
  localparam int DIST_X_W     = WIDTH_KEEP_W + $clog2(DIST_NUM);
  localparam int DIST_Q_W     = DIST_W + 1;
  localparam int DIST_K       = DIST_X_W + $clog2(DIST_DEN);
  localparam longint DIST_RECIP = ((64'd1 << DIST_K) + DIST_DEN - 1) / DIST_DEN;
  localparam int DIST_RECIP_W = $clog2(DIST_RECIP + 1);
  localparam int DIST_PROD_W  = DIST_X_W + DIST_RECIP_W;

  // Window average: floor(sum / WINDOW_LENGTH) by reciprocal multiplication.
  localparam int SUM_W        = DIST_W + $clog2(WINDOW_LENGTH + 1);
  localparam int AVG_K        = SUM_W + $clog2(WINDOW_LENGTH + 1);
  localparam longint AVG_RECIP = ((64'd1 << AVG_K) + WINDOW_LENGTH - 1) / WINDOW_LENGTH;
  localparam int AVG_RECIP_W  = $clog2(AVG_RECIP + 1);
  localparam int AVG_PROD_W   = SUM_W + AVG_RECIP_W;

  typedef logic [SENSOR_W-1:0] sensor_t;
  typedef logic [DIST_W-1:0]   dist_t;
  typedef logic [CM_W-1:0]     cm_t;
  typedef logic [TIME_W-1:0]   stamp_t;
  typedef logic [POS_W-1:0]    pos_t;
  typedef logic [SUM_W-1:0]    sum_t;
  typedef logic [WINDOW_LENGTH-1:0][DIST_W-1:0] row_t;

endpackage

/* src/eds_if.sv */
// Channel interfaces: measurement input, smoothed result output and configuration write.
interface eds_meas_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               sensor;
  logic                     echo_received;
  logic [31:0]              rise_time;
  logic [31:0]              fall_time;

  modport source (output valid, output sensor, output echo_received, output rise_time,
                  output fall_time, input ready);
  modport sink   (input valid, input sensor, input echo_received, input rise_time,
                  input fall_time, output ready);
endinterface

interface eds_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_sensor;
  logic [13:0] smoothed_distance;

  modport source (output valid, output out_sensor, output smoothed_distance, input ready);
  modport sink   (input valid, input out_sensor, input smoothed_distance, output ready);
endinterface

interface eds_cfg_if;
  logic       valid;
  logic       ready;
  logic [9:0] max_distance_cm;

  modport source (output valid, output max_distance_cm, input ready);
  modport sink   (input valid, input max_distance_cm, output ready);
endinterface

/* src/echo_distance_smoother.sv */
// Ultrasonic echo distance smoother: converts echo timing to distance and averages it per sensor.
// The block is a four-register pipeline (input, sample, window sum, result) that takes one
// measurement beat per cycle while input ready is high and returns one result beat per
// in-range measurement from the result register. Each stage holds its beat while the next one
// is full, and empty stages are filled at once, so input ready only drops when every stage is
// occupied and the result is not being taken. Measurements for a sensor index at or above the
// sensor count are accepted and dropped without a result. The per-sensor window is updated in
// the sample stage, so back-to-back beats for the same sensor see each other's samples.
// The maximum distance register is always ready and should only be written while idle.
module echo_distance_smoother (
  input  logic clk,
  input  logic rst,
  eds_meas_if.sink   meas,
  eds_res_if.source  res,
  eds_cfg_if.sink    cfg
);
  import eds_pkg::*;

  // Configuration.
  cm_t max_cm;

  // Input stage.
  logic    in_vld;
  sensor_t in_sensor;
  logic    in_echo;
  stamp_t  in_rise;
  stamp_t  in_fall;

  // Sample stage.
  logic    smp_vld;
  sensor_t smp_sensor;
  dist_t   smp_dist;

  // Sum stage.
  logic    sum_vld;
  sensor_t sum_sensor;
  sum_t    sum_val;

  // Result stage.
  logic    out_vld;
  sensor_t out_sensor_r;
  dist_t   out_dist;

  // Per-sensor window state; window rows have no reset and are always filled on first use.
  row_t  win [SENSOR_COUNT];
  pos_t  wpos [SENSOR_COUNT];
  logic [SENSOR_COUNT-1:0] window_filled;

  logic take_out, take_sum, take_smp, take_in;
  logic in_range;

  dist_t                  limit;
  logic [TIME_W:0]        diff;
  logic [DIST_X_W-1:0]    dist_x;
  logic [DIST_PROD_W-1:0] dist_prod;
  logic [DIST_Q_W-1:0]    dist_q;
  dist_t                  sample;

  row_t                   row_next;
  pos_t                   pos_next;
  sum_t                   row_sum;
  logic [AVG_PROD_W-1:0]  avg_prod;

  assign take_out = !out_vld || res.ready;
  assign take_sum = !sum_vld || take_out;
  assign take_smp = !smp_vld || take_sum;
  assign take_in  = !in_vld  || take_smp;

  assign meas.ready = take_in;
  assign cfg.ready  = 1'b1;
  assign in_range   = {1'b0, meas.sensor} < (SENSOR_W + 1)'(SENSOR_COUNT);

  assign res.valid             = out_vld;
  assign res.out_sensor        = out_sensor_r;
  assign res.smoothed_distance = out_dist;

  // Pulse width to distance, with saturation at the configured limit.
  always_comb begin
    limit     = {max_cm, {FRAC_W{1'b0}}};
    diff      = {1'b0, in_fall} - {1'b0, in_rise};
    dist_x    = {diff[WIDTH_KEEP_W-1:0], {(DIST_X_W - WIDTH_KEEP_W){1'b0}}};
    dist_prod = DIST_PROD_W'(dist_x) * DIST_PROD_W'(DIST_RECIP);
    dist_q    = dist_prod[DIST_K +: DIST_Q_W];
    if (!in_echo) begin
      sample = limit;
    end else if (diff[TIME_W] || diff[TIME_W-1:0] == '0) begin
      // Falling edge not later than rising edge: zero width.
      sample = '0;
    end else if (diff[TIME_W-1:WIDTH_KEEP_W] != '0) begin
      sample = limit;
    end else if (dist_q > {1'b0, limit}) begin
      sample = limit;
    end else begin
      sample = dist_q[DIST_W-1:0];
    end
  end

  // Window update for the sensor in the sample stage, and the sum of the new window.
  always_comb begin
    if (!window_filled[smp_sensor]) begin
      for (int i = 0; i < WINDOW_LENGTH; i++) begin
        row_next[i] = smp_dist;
      end
    end else begin
      row_next = win[smp_sensor];
      row_next[wpos[smp_sensor]] = smp_dist;
    end
    if (wpos[smp_sensor] == POS_W'(WINDOW_LENGTH - 1)) begin
      pos_next = '0;
    end else begin
      pos_next = wpos[smp_sensor] + POS_W'(1);
    end
    row_sum = '0;
    for (int i = 0; i < WINDOW_LENGTH; i++) begin
      row_sum = row_sum + SUM_W'(row_next[i]);
    end
  end

  assign avg_prod = AVG_PROD_W'(sum_val) * AVG_PROD_W'(AVG_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_cm        <= MAX_CM_RESET;
      in_vld        <= 1'b0;
      smp_vld       <= 1'b0;
      sum_vld       <= 1'b0;
      out_vld       <= 1'b0;
      window_filled <= '0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        wpos[i] <= '0;
      end
    end else begin
      if (cfg.valid) begin
        max_cm <= cfg.max_distance_cm;
      end
      if (take_in) begin
        in_vld <= meas.valid && in_range;
      end
      if (take_smp) begin
        smp_vld <= in_vld;
      end
      if (take_sum) begin
        sum_vld <= smp_vld;
        if (smp_vld) begin
          window_filled[smp_sensor] <= 1'b1;
          wpos[smp_sensor]          <= pos_next;
        end
      end
      if (take_out) begin
        out_vld <= sum_vld;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (take_in) begin
      in_sensor <= meas.sensor;
      in_echo   <= meas.echo_received;
      in_rise   <= meas.rise_time;
      in_fall   <= meas.fall_time;
    end
    if (take_smp) begin
      smp_sensor <= in_sensor;
      smp_dist   <= sample;
    end
    if (take_sum) begin
      sum_sensor <= smp_sensor;
      sum_val    <= row_sum;
      if (smp_vld) begin
        win[smp_sensor] <= row_next;
      end
    end
    if (take_out) begin
      out_sensor_r <= sum_sensor;
      out_dist     <= avg_prod[AVG_K +: DIST_W];
    end
  end

  // A sample never exceeds the configured limit.
  a_sample_limit: assert property (@(posedge clk) disable iff (rst)
    smp_vld |-> smp_dist <= {max_cm, {FRAC_W{1'b0}}})
    else $error("sample above saturation limit");

  // Once a sample has entered a sensor's window, that window counts as filled.
  a_filled_after_write: assert property (@(posedge clk) disable iff (rst)
    (smp_vld && take_sum) |=> window_filled[$past(smp_sensor)])
    else $error("window not marked filled after a write");

  // The write position of the active sensor stays inside its window.
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    smp_vld |-> wpos[smp_sensor] < POS_W'(WINDOW_LENGTH))
    else $error("write position outside window");

endmodule

/* bench/eds_average_checker.sv */
// Checker for the echo distance smoother: predicts each smoothed distance and compares it.
module eds_average_checker (
  input  logic clk,
  input  logic rst,
  eds_meas_if  meas,
  eds_res_if   res,
  eds_cfg_if   cfg,
  output int   mismatches,
  output int   waiting
);
  timeunit 1ns;
  timeprecision 1ps;
  import eds_pkg::*;

  typedef struct packed {
    sensor_t sensor;
    dist_t   distance;
  } average_t;

  average_t expected_averages[$];
  dist_t    window_rows [SENSOR_COUNT][WINDOW_LENGTH];
  pos_t     next_slot [SENSOR_COUNT];
  logic     row_primed [SENSOR_COUNT];
  cm_t      limit_cm;

  // Pulse width in microseconds to distance in sixteenths of a centimetre, clipped at the limit.
  function automatic dist_t echo_distance(logic echo, stamp_t rise, stamp_t fall);
    logic [63:0] pulse;
    logic [63:0] scaled;
    logic [63:0] ceiling;
    ceiling = 64'(limit_cm) * 64'd16;
    if (!echo) return dist_t'(ceiling);
    pulse = (fall > rise) ? 64'(fall - rise) : 64'd0;
    scaled = (pulse * 64'd16) / 64'd58;
    if (scaled > ceiling) scaled = ceiling;
    return dist_t'(scaled);
  endfunction

  task automatic predict_average(sensor_t s, dist_t sample);
    int total;
    total = 0;
    // A sensor's first sample stands for its whole window.
    if (!row_primed[s]) begin
      for (int i = 0; i < WINDOW_LENGTH; i++) window_rows[s][i] = sample;
      row_primed[s] = 1'b1;
    end
    window_rows[s][next_slot[s]] = sample;
    next_slot[s] = (next_slot[s] == pos_t'(WINDOW_LENGTH - 1)) ? '0 : next_slot[s] + 1'b1;
    for (int i = 0; i < WINDOW_LENGTH; i++) total += int'(window_rows[s][i]);
    expected_averages.push_back('{s, dist_t'(total / WINDOW_LENGTH)});
  endtask

  always @(posedge clk) begin
    average_t want;
    if (rst) begin
      expected_averages.delete();
      for (int s = 0; s < SENSOR_COUNT; s++) begin
        next_slot[s]  = '0;
        row_primed[s] = 1'b0;
      end
      limit_cm = MAX_CM_RESET;
      mismatches = 0;
    end else begin
      if (res.valid && res.ready) begin
        if (expected_averages.size() == 0) begin
          $error("unexpected result beat: out_sensor %0d smoothed_distance %0d",
                 res.out_sensor, res.smoothed_distance);
          mismatches++;
        end else begin
          want = expected_averages.pop_front();
          if (res.out_sensor !== want.sensor) begin
            $error("out_sensor: expected %0d, actual %0d", want.sensor, res.out_sensor);
            mismatches++;
          end
          if (res.smoothed_distance !== want.distance) begin
            $error("smoothed_distance: expected %0d, actual %0d",
                   want.distance, res.smoothed_distance);
            mismatches++;
          end
        end
      end
      if (cfg.valid && cfg.ready) limit_cm = cfg.max_distance_cm;
      // Beats for a sensor beyond the last one are dropped without a result.
      if (meas.valid && meas.ready && meas.sensor < SENSOR_COUNT)
        predict_average(meas.sensor,
                        echo_distance(meas.echo_received, meas.rise_time, meas.fall_time));
    end
    waiting <= expected_averages.size();
  end

endmodule

/* bench/echo_distance_smoother_tb.sv */
// Testbench top for the echo distance smoother: clock, reset, stimulus and verdict.
module echo_distance_smoother_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import eds_pkg::*;

  localparam int CYCLE_LIMIT        = 300000;
  localparam int SETTLE_CYCLES      = 12;
  localparam int HOLD_CYCLES        = 300;
  localparam int RANDOM_PER_SETTING = 290;
  localparam int SETTING_COUNT      = 6;
  localparam int PRESSURE_SETTING   = 4;
  localparam cm_t MAX_SETTINGS [SETTING_COUNT] = '{cm_t'(1023), cm_t'(0), cm_t'(1),
                                                  cm_t'(513), cm_t'(400), cm_t'(1023)};

  logic clk = 1'b0;
  logic rst;
  int   send_gap_pct;
  int   take_gap_pct;
  int   setting;
  logic stall_results;
  int   cycle_count;
  int   mismatches;
  int   waiting;

  eds_meas_if meas ();
  eds_res_if  res ();
  eds_cfg_if  cfg ();

  echo_distance_smoother i_dut (
    .clk  (clk),
    .rst  (rst),
    .meas (meas),
    .res  (res),
    .cfg  (cfg)
  );

  eds_average_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .meas       (meas),
    .res        (res),
    .cfg        (cfg),
    .mismatches (mismatches),
    .waiting    (waiting)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("echo_distance_smoother test failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    res.ready <= !stall_results && ($urandom_range(99) >= take_gap_pct);
  end

  // Holds the result side off long enough for the pipeline to fill and stall its input.
  initial begin
    stall_results = 1'b0;
    wait (setting == PRESSURE_SETTING);
    @(posedge clk);
    stall_results <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    stall_results <= 1'b0;
  end

  // Entered and left at a falling edge; valid stays high after the beat until the next call.
  task automatic send_measurement(sensor_t s, logic echo, stamp_t rise, stamp_t fall);
    while ($urandom_range(99) < send_gap_pct) begin
      meas.valid <= 1'b0;
      @(negedge clk);
    end
    meas.valid         <= 1'b1;
    meas.sensor        <= s;
    meas.echo_received <= echo;
    meas.rise_time     <= rise;
    meas.fall_time     <= fall;
    @(posedge clk);
    while (!meas.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_max_distance(cm_t value);
    meas.valid <= 1'b0;
    @(negedge clk);
    while (waiting != 0) @(negedge clk);
    // Dropped beats leave no expectation but may still be in flight.
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg.valid           <= 1'b1;
    cfg.max_distance_cm <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic send_random_measurement(cm_t limit, output bit counted);
    sensor_t     s;
    logic        echo;
    stamp_t      rise;
    stamp_t      fall;
    int unsigned pulse;
    int unsigned kind;
    s    = ($urandom_range(99) < 6) ? sensor_t'(3) : sensor_t'($urandom_range(SENSOR_COUNT - 1));
    echo = ($urandom_range(99) >= 10);
    rise = $urandom();
    kind = $urandom_range(10);
    case (kind)
      0, 1, 2, 3: pulse = $urandom_range(3000);
      4, 5:       pulse = $urandom_range(70000);
      // Around the width at which the distance reaches the limit.
      6, 7:       pulse = int'(limit) * 58 + $urandom_range(120) - 60;
      10:         pulse = 32'h1_0000 + $urandom_range(200) - 100;
      default:    pulse = 0;
    endcase
    if (int'(limit) * 58 < 60 && (kind == 6 || kind == 7)) pulse = $urandom_range(120);
    if (kind == 8) fall = $urandom();
    else if (kind == 9) fall = rise - $urandom_range(1000);
    else fall = rise + pulse;
    send_measurement(s, echo, rise, fall);
    counted = (s < SENSOR_COUNT);
  endtask

  initial begin
    bit  counted;
    int  taken;
    cm_t limit;
    rst                 = 1'b1;
    meas.valid          = 1'b0;
    meas.sensor         = '0;
    meas.echo_received  = 1'b0;
    meas.rise_time      = '0;
    meas.fall_time      = '0;
    res.ready           = 1'b0;
    cfg.valid           = 1'b0;
    cfg.max_distance_cm = '0;
    send_gap_pct        = 0;
    take_gap_pct        = 0;
    setting             = -1;
    cycle_count         = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed beats at the reset maximum of 400 cm.
    send_measurement(2'd0, 1'b1, 32'd0, 32'd0);
    send_measurement(2'd0, 1'b1, 32'd100, 32'd50);
    send_measurement(2'd0, 1'b1, 32'd7, 32'd65);
    send_measurement(2'd0, 1'b1, 32'd0, 32'd57);
    send_measurement(2'd0, 1'b1, 32'd1000, 32'd4000);
    send_measurement(2'd0, 1'b1, 32'd0, 32'd23200);
    send_measurement(2'd0, 1'b1, 32'd0, 32'd23201);
    send_measurement(2'd0, 1'b1, 32'hFFFF_FF00, 32'hFFFF_FFFF);
    send_measurement(2'd1, 1'b0, 32'd0, 32'hFFFF_FFFF);
    send_measurement(2'd1, 1'b1, 32'd0, 32'hFFFF_FFFF);
    send_measurement(2'd1, 1'b1, 32'd0, 32'd65535);
    send_measurement(2'd1, 1'b1, 32'd0, 32'd65536);
    send_measurement(2'd2, 1'b1, 32'hFFFF_FFFF, 32'd0);
    send_measurement(2'd2, 1'b1, 32'd5, 32'd5);
    send_measurement(2'd3, 1'b1, 32'd0, 32'd1000);
    send_measurement(2'd3, 1'b0, 32'd0, 32'd0);
    send_measurement(2'd2, 1'b1, 32'd0, 32'd5800);
    send_measurement(2'd2, 1'b0, 32'd10, 32'd20);
    send_measurement(2'd1, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
    send_measurement(2'd1, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000);
    send_measurement(2'd2, 1'b1, 32'hFFFF_0000, 32'hFFFF_FFFF);
    send_measurement(2'd0, 1'b1, 32'd0, 32'd580);
    send_measurement(2'd0, 1'b1, 32'd0, 32'd1160);
    send_measurement(2'd0, 1'b0, 32'd0, 32'd0);
    send_measurement(2'd0, 1'b1, 32'd3, 32'd2003);

    for (int k = 0; k < SETTING_COUNT; k++) begin
      send_gap_pct = (k < 2) ? 12 : (k < 4) ? 59 : 0;
      take_gap_pct = (k < 2) ? 59 : (k < 4) ? 12 : 0;
      limit = (k == PRESSURE_SETTING) ? cm_t'($urandom_range(1022, 2)) : MAX_SETTINGS[k];
      write_max_distance(limit);
      setting = k;
      taken = 0;
      while (taken < RANDOM_PER_SETTING) begin
        send_random_measurement(limit, counted);
        if (counted) taken++;
      end
    end

    meas.valid <= 1'b0;
    while (waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && waiting == 0) begin
      $display("echo_distance_smoother test passed");
    end else begin
      $display("echo_distance_smoother test failed");
    end
    $finish;
  end

endmodule

/* echo_distance_smoother.f */
src/eds_pkg.sv
src/eds_if.sv
src/echo_distance_smoother.sv
bench/eds_average_checker.sv
bench/echo_distance_smoother_tb.sv
